/* rtl/cht_pkg.sv */
`default_nettype none
package cht_pkg;
    localparam int NodeBits   = 10;
    localparam int NodeCount  = 1 << NodeBits;
    localparam int BucketBits = 10;
    localparam int MaxBuckets = 1 << BucketBits;
    localparam int LinkBits   = NodeBits + 1;
    localparam int CountBits  = 11;
    localparam int KeyBits    = 64;
    localparam int CfgBits    = 4;

    localparam logic [LinkBits-1:0] NoLink = LinkBits'(NodeCount);

    localparam logic [1:0] CmdAdd    = 2'd0;
    localparam logic [1:0] CmdFind   = 2'd1;
    localparam logic [1:0] CmdDelKey = 2'd2;
    localparam logic [1:0] CmdDelNode = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [KeyBits-1:0] key;
        logic [NodeBits-1:0] node_index;
    } t_req;

    typedef struct packed {
        logic                 status;
        logic [NodeBits-1:0]  found_node;
        logic [CountBits-1:0] element_count;
        logic [CountBits-1:0] busy_buckets;
    } t_rsp;
endpackage
`default_nettype wire

/* rtl/cht_if.sv */
`default_nettype none
interface cht_req_if;
    logic          valid;
    logic          ready;
    cht_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cht_rsp_if;
    logic          valid;
    logic          ready;
    cht_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/cht_hash.sv */
`default_nettype none
// Mix hash computed one step per cycle through a shared add/xor unit.
// The multiply by 21 is done as k + (k<<2) + (k<<4) over two steps.
module cht_hash (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [cht_pkg::KeyBits-1:0] i_key,
    output logic                            o_done,
    output logic [31:0]                     o_hash
);
    logic [cht_pkg::KeyBits-1:0] r_k, r_t;
    logic [2:0] r_step;
    logic       r_run;
    logic [cht_pkg::KeyBits-1:0] w_a, w_b, w_res;
    logic                        w_xor;

    always_comb begin
        w_a   = r_k;
        w_b   = '0;
        w_xor = 1'b0;
        unique case (r_step)
            3'd0: begin w_a = ~r_k; w_b = r_k << 18; end
            3'd1: begin w_b = r_k >> 31; w_xor = 1'b1; end
            3'd2: begin w_b = r_k << 2; end
            3'd3: begin w_a = r_t; w_b = r_k << 4; end
            3'd4: begin w_b = r_k >> 11; w_xor = 1'b1; end
            3'd5: begin w_b = r_k << 6; end
            3'd6: begin w_b = r_k >> 22; w_xor = 1'b1; end
            default: begin w_b = '0; end
        endcase
        w_res = w_xor ? (w_a ^ w_b) : (w_a + w_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_k    <= i_key;
                r_step <= '0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                if (r_step == 3'd2) r_t <= w_res;
                else r_k <= w_res;
                r_step <= r_step + 3'd1;
                if (r_step == 3'd6) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_hash = r_k[31:0];
endmodule
`default_nettype wire

/* rtl/chained_hash_table_engine.sv */
`default_nettype none
// Channel  Dir  Payload
// req      in   cmd, key, node_index
// rsp      out  status, found_node, element_count, busy_buckets
// cfg      in   bucket_bits, written whenever the write enable is high
// A find steps through hash start, the hash, head read and result, with a node read per chain node visited.
// An add first checks its node is free and adds an insert step; a delete by key adds an unlink
// and, if a node follows, a fix-up; a delete by node checks its node is in use, then unlinks it.
// After reset a clearing pass over every bucket runs with no request accepted.
// A result waits in its output register while the next request is worked on;
// that request holds in its result state until the register is free.
module chained_hash_table_engine (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [cht_pkg::CfgBits-1:0] i_cfg_data,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp
);
    localparam int NB = cht_pkg::NodeBits;
    localparam int LB = cht_pkg::LinkBits;
    localparam int BB = cht_pkg::BucketBits;
    localparam int CB = cht_pkg::CountBits;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH_GO, S_HASH_KEY, S_HEAD_RD, S_HEAD_WAIT, S_NODE_RD,
        S_NODE_WAIT, S_ADD, S_UNLINK, S_FIX_NEXT, S_RESP, S_DN_RD, S_DN_WAIT
    } t_state;

    t_state r_state;
    logic [CB-1:0] r_elems, r_busy;
    logic [cht_pkg::CfgBits-1:0] r_bits;

    logic          m_used [cht_pkg::NodeCount];
    logic [LB-1:0] m_head [cht_pkg::MaxBuckets];
    logic [cht_pkg::KeyBits-1:0] m_key [cht_pkg::NodeCount];
    logic [LB-1:0] m_prev [cht_pkg::NodeCount];
    logic [LB-1:0] m_next [cht_pkg::NodeCount];

    cht_pkg::t_req r_req;
    logic [BB-1:0] r_bucket, r_clr;
    logic [LB-1:0] r_cur, r_head, r_rd_head;
    logic [cht_pkg::KeyBits-1:0] r_rd_key;
    logic [LB-1:0] r_rd_prev, r_rd_next;
    logic          r_rd_used;
    logic [NB-1:0] r_addr;
    logic          r_found;
    cht_pkg::t_rsp r_rsp;
    logic          r_rsp_valid;

    logic        w_hash_start;
    logic        w_hash_done;
    logic [31:0] w_hash;
    logic [cht_pkg::KeyBits-1:0] w_hkey;
    logic [BB-1:0] w_bucket;
    logic [3:0]    w_bits;

    // Head memory write port and node-in-use write port.
    logic          w_hd_we;
    logic [BB-1:0] w_hd_addr;
    logic [LB-1:0] w_hd_data;
    logic          w_us_we;
    logic [NB-1:0] w_us_addr;
    logic          w_us_data;

    // A delete by node hashes the key stored in the node, read beforehand.
    assign w_hkey = (r_req.cmd == cht_pkg::CmdDelNode) ? r_rd_key : r_req.key;

    cht_hash u_hash (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_hash_start),
        .i_key  (w_hkey),
        .o_done (w_hash_done),
        .o_hash (w_hash)
    );

    always_comb begin
        w_bits = (r_bits == 4'd0) ? 4'd1 : ((r_bits > 4'd10) ? 4'd10 : r_bits);
        w_bucket = w_hash[BB-1:0] & BB'((11'd1 << w_bits) - 11'd1);
    end

    assign w_hash_start = (r_state == S_HASH_GO);
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        w_hd_we   = 1'b0;
        w_hd_addr = r_bucket;
        w_hd_data = LB'(r_req.node_index);
        if (r_state == S_CLEAR) begin
            w_hd_we = 1'b1; w_hd_addr = r_clr; w_hd_data = cht_pkg::NoLink;
        end else if (r_state == S_ADD) begin
            w_hd_we = 1'b1; w_hd_data = LB'(r_req.node_index);
        end else if (r_state == S_UNLINK && r_rd_prev[NB] && r_rd_head == r_cur) begin
            w_hd_we = 1'b1; w_hd_data = r_rd_next[NB] ? cht_pkg::NoLink : r_rd_next;
        end
    end

    always_comb begin
        w_us_we   = 1'b0;
        w_us_addr = r_req.node_index;
        w_us_data = 1'b0;
        if (r_state == S_CLEAR) begin
            w_us_we = 1'b1; w_us_addr = NB'(r_clr);
        end else if (r_state == S_ADD) begin
            w_us_we = 1'b1; w_us_data = 1'b1;
        end else if (r_state == S_UNLINK) begin
            w_us_we = 1'b1; w_us_addr = r_cur[NB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hd_we) m_head[w_hd_addr] <= w_hd_data;
        r_rd_head <= m_head[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (w_us_we) m_used[w_us_addr] <= w_us_data;
        r_rd_used <= m_used[r_addr];
        r_rd_key  <= m_key[r_addr];
        r_rd_prev <= m_prev[r_addr];
        r_rd_next <= m_next[r_addr];
        if (r_state == S_ADD) begin
            m_key[r_req.node_index]  <= r_req.key;
            m_next[r_req.node_index] <= r_rd_head;
        end else if (r_state == S_UNLINK && !r_rd_prev[NB]) begin
            m_next[r_rd_prev[NB-1:0]] <= r_rd_next[NB] ? cht_pkg::NoLink : r_rd_next;
        end
        if (r_state == S_ADD) begin
            m_prev[r_req.node_index] <= cht_pkg::NoLink;
        end else if (r_state == S_FIX_NEXT) begin
            m_prev[r_rd_next[NB-1:0]] <= r_rd_prev[NB] ? cht_pkg::NoLink : r_rd_prev;
        end else if (r_state == S_RESP && r_req.cmd == cht_pkg::CmdAdd && r_found
                && !r_head[NB]) begin
            // The old head of the chain now follows the added node.
            m_prev[r_head[NB-1:0]] <= LB'(r_req.node_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_bits      <= 4'd10;
            r_elems     <= '0;
            r_busy      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_bits <= i_cfg_data;
            if (o_rsp.valid && o_rsp.ready) r_rsp_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BB'(1);
                    if (r_clr == BB'(cht_pkg::MaxBuckets - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req   <= i_req.payload;
                        r_found <= 1'b0;
                        r_addr  <= i_req.payload.node_index;
                        r_cur   <= LB'(i_req.payload.node_index);
                        if (i_req.payload.cmd == cht_pkg::CmdDelNode
                                || i_req.payload.cmd == cht_pkg::CmdAdd) begin
                            r_state <= S_DN_RD;
                        end else begin
                            r_state <= S_HASH_GO;
                        end
                    end
                end
                S_DN_RD:   r_state <= S_DN_WAIT;
                S_DN_WAIT: begin
                    // An add needs a free node, a delete by node one in use.
                    if (r_req.cmd == cht_pkg::CmdAdd) begin
                        r_state <= r_rd_used ? S_RESP : S_HASH_GO;
                    end else begin
                        r_state <= r_rd_used ? S_HASH_GO : S_RESP;
                    end
                end
                S_HASH_GO: r_state <= S_HASH_KEY;
                S_HASH_KEY: begin
                    if (w_hash_done) begin
                        r_bucket <= w_bucket;
                        r_state  <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD:   r_state <= S_HEAD_WAIT;
                S_HEAD_WAIT: begin
                    r_head <= r_rd_head;
                    if (r_req.cmd == cht_pkg::CmdDelNode) begin
                        r_state <= S_UNLINK;
                    end else begin
                        r_cur   <= r_rd_head;
                        r_addr  <= r_rd_head[NB-1:0];
                        r_state <= S_NODE_RD;
                    end
                end
                S_NODE_RD: begin
                    if (r_cur[NB]) begin
                        r_state <= (r_req.cmd == cht_pkg::CmdAdd) ? S_ADD : S_RESP;
                    end else begin
                        r_state <= S_NODE_WAIT;
                    end
                end
                S_NODE_WAIT: begin
                    if (!r_rd_used) begin
                        r_state <= (r_req.cmd == cht_pkg::CmdAdd) ? S_ADD : S_RESP;
                    end else if (r_rd_key == r_req.key) begin
                        // A key that is already stored makes an add fail.
                        if (r_req.cmd != cht_pkg::CmdAdd) r_found <= 1'b1;
                        unique case (r_req.cmd)
                            cht_pkg::CmdDelKey: r_state <= S_UNLINK;
                            default:            r_state <= S_RESP;
                        endcase
                    end else begin
                        r_cur   <= r_rd_next;
                        r_addr  <= r_rd_next[NB-1:0];
                        r_state <= S_NODE_RD;
                    end
                end
                S_ADD: begin
                    r_found <= 1'b1;
                    r_elems <= r_elems + CB'(1);
                    if (r_head[NB] && r_busy < CB'(cht_pkg::MaxBuckets)) r_busy <= r_busy + CB'(1);
                    r_state <= S_RESP;
                end
                S_UNLINK: begin
                    r_found <= 1'b1;
                    if (r_elems != '0) r_elems <= r_elems - CB'(1);
                    if (r_rd_prev[NB] && r_rd_head == r_cur && r_rd_next[NB] && r_busy != '0)
                        r_busy <= r_busy - CB'(1);
                    r_state <= r_rd_next[NB] ? S_RESP : S_FIX_NEXT;
                end
                S_FIX_NEXT: r_state <= S_RESP;
                S_RESP: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp.status        <= !r_found;
                        r_rsp.found_node    <= (r_found && r_req.cmd == cht_pkg::CmdFind)
                                               ? r_cur[NB-1:0] : '0;
                        r_rsp.element_count <= r_elems;
                        r_rsp.busy_buckets  <= r_busy;
                        r_rsp_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
